FILE: sv/gaussian_window_smoother_macros.svh
// assertion macros shared by the smoother rtl
`ifndef GAUSSIAN_WINDOW_SMOOTHER_MACROS_SVH
`define GAUSSIAN_WINDOW_SMOOTHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must never hold outside reset
`define GWS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

// ante implies cons in the same cycle
`define GWS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define GWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GWS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`define GWS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define GWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: sv/gws_pkg.sv
`default_nettype none

package gws_pkg;

    localparam int PIX_W          = 8;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_KERNEL_DEF = 7;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int COORD_W        = 10;
    localparam int SUM_W          = 18;
    localparam int KSUM_W         = 10;
    localparam int DIV_SHIFT      = 20;
    localparam int RECIP_W        = 17;
    localparam int PIPE_LAT       = 7;
    localparam int OUT_DEPTH      = 16;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_W-1:0] MAX_HEIGHT   = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_KERNEL_SELECT = 2'd2
    } gws_cfg_idx_t;

    typedef enum logic [1:0] {
        KSEL_3X3 = 2'd0,
        KSEL_5X5 = 2'd1,
        KSEL_7X7 = 2'd2
    } gws_ksel_t;

    localparam int KSUM_3 = 16;
    localparam int KSUM_5 = 273;
    localparam int KSUM_7 = 1003;

    localparam int RECIP_3 = (1 << DIV_SHIFT) / KSUM_3;
    localparam int RECIP_5 = (1 << DIV_SHIFT) / KSUM_5;
    localparam int RECIP_7 = (1 << DIV_SHIFT) / KSUM_7;

    localparam logic [7:0] K3 [9] = '{8'd1, 8'd2, 8'd1, 8'd2, 8'd4, 8'd2, 8'd1, 8'd2, 8'd1};

    localparam logic [7:0] K5 [25] = '{
        8'd1, 8'd4,  8'd7,  8'd4,  8'd1,
        8'd4, 8'd16, 8'd26, 8'd16, 8'd4,
        8'd7, 8'd26, 8'd41, 8'd26, 8'd7,
        8'd4, 8'd16, 8'd26, 8'd16, 8'd4,
        8'd1, 8'd4,  8'd7,  8'd4,  8'd1
    };

    localparam logic [7:0] K7 [49] = '{
        8'd0, 8'd0,  8'd1,  8'd2,   8'd1,  8'd0,  8'd0,
        8'd0, 8'd3,  8'd13, 8'd22,  8'd13, 8'd3,  8'd0,
        8'd1, 8'd13, 8'd59, 8'd97,  8'd59, 8'd13, 8'd1,
        8'd2, 8'd22, 8'd97, 8'd159, 8'd97, 8'd22, 8'd2,
        8'd1, 8'd13, 8'd59, 8'd97,  8'd59, 8'd13, 8'd1,
        8'd0, 8'd3,  8'd13, 8'd22,  8'd13, 8'd3,  8'd0,
        8'd0, 8'd0,  8'd1,  8'd2,   8'd1,  8'd0,  8'd0
    };

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } gws_pixel_t;

    typedef struct packed {
        logic             frame_start;
        logic [PIX_W-1:0] pixel_red;
        logic [PIX_W-1:0] pixel_green;
        logic [PIX_W-1:0] pixel_blue;
    } gws_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]   smooth_red;
        logic [PIX_W-1:0]   smooth_green;
        logic [PIX_W-1:0]   smooth_blue;
        logic [COORD_W-1:0] centre_col;
        logic [COORD_W-1:0] centre_row;
    } gws_out_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } gws_sums_t;

    // kernel tap at row a, column b of the selected kernel
    function automatic logic [7:0] gws_weight(input gws_ksel_t sel, input int a, input int b);
        logic [7:0] wt;
        case (sel)
            KSEL_3X3: wt = K3[a * 3 + b];
            KSEL_5X5: wt = K5[a * 5 + b];
            default:  wt = K7[a * 7 + b];
        endcase
        return wt;
    endfunction

    function automatic logic [KSUM_W-1:0] gws_ksum(input gws_ksel_t sel);
        logic [KSUM_W-1:0] s;
        case (sel)
            KSEL_3X3: s = KSUM_W'(KSUM_3);
            KSEL_5X5: s = KSUM_W'(KSUM_5);
            default:  s = KSUM_W'(KSUM_7);
        endcase
        return s;
    endfunction

    // floor(2^DIV_SHIFT / kernel sum)
    function automatic logic [RECIP_W-1:0] gws_recip(input gws_ksel_t sel);
        logic [RECIP_W-1:0] m;
        case (sel)
            KSEL_3X3: m = RECIP_W'(RECIP_3);
            KSEL_5X5: m = RECIP_W'(RECIP_5);
            default:  m = RECIP_W'(RECIP_7);
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: sv/gaussian_window_smoother.sv
// channel  dir  signals                                  beat
// s_       in   s_valid s_ready s_data                   one rgb pixel, raster order
// m_       out  m_valid m_ready m_data                   one smoothed interior pixel + centre
// cfg_     in   cfg_valid cfg_ready cfg_index cfg_data   one register write
//
// one pixel per cycle while s_ready is high; each result passes cells, total, divider
// the line store has one read and one write port, both used every pixel cycle
// up to 16 owed results are buffered; s_ready drops only when all 16 are owed
// reset is synchronous; the line store and window start undefined, no clearing pass
// border pixels are consumed and shift the window but give no beat
`default_nettype none

`include "gaussian_window_smoother_macros.svh"

module gaussian_window_smoother #(
    parameter int MAX_WIDTH  = gws_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = gws_pkg::MAX_KERNEL_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire gws_pkg::gws_in_t              s_data,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output gws_pkg::gws_out_t                  m_data,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gws_pkg::CFG_W-1:0]     cfg_data
);

    // column counter width and a compare width that holds both it and the register
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int EW      = (COL_W + 1 > gws_pkg::CFG_W) ? COL_W + 1 : gws_pkg::CFG_W;
    localparam int ROWS    = MAX_KERNEL - 1;
    localparam int LINE_W  = ROWS * $bits(gws_pkg::gws_pixel_t);
    localparam int PTR_W   = $clog2(gws_pkg::OUT_DEPTH);
    localparam int CW      = gws_pkg::COORD_W;
    // largest selector whose kernel fits the window
    localparam logic [1:0] SEL_MAX = 2'((MAX_KERNEL - 1) / 2 - 1);
    localparam logic [PTR_W:0] OUT_FULL = (PTR_W + 1)'(gws_pkg::OUT_DEPTH);

    typedef struct packed {
        logic          emit;
        logic [CW-1:0] col;
        logic [CW-1:0] row;
    } meta_t;

    // ---------------- configuration registers ----------------
    logic [gws_pkg::CFG_W-1:0] width_reg;
    logic [gws_pkg::CFG_W-1:0] height_reg;
    logic [1:0]                kernel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= gws_pkg::WIDTH_RESET;
            height_reg <= gws_pkg::HEIGHT_RESET;
            kernel_reg <= 2'(gws_pkg::KSEL_3X3);
        end else if (cfg_valid && cfg_ready) begin
            unique case (gws_pkg::gws_cfg_idx_t'(cfg_index))
                gws_pkg::CFG_FRAME_WIDTH:   width_reg  <= cfg_data;
                gws_pkg::CFG_FRAME_HEIGHT:  height_reg <= cfg_data;
                gws_pkg::CFG_KERNEL_SELECT: kernel_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // clamp selector and frame size into what the hardware supports
    logic [1:0]                sel_clip;
    gws_pkg::gws_ksel_t        eff_sel;
    logic [EW-1:0]             w_eff;
    logic [gws_pkg::CFG_W-1:0] h_eff;
    logic [EW-1:0]             k_col;
    logic [gws_pkg::CFG_W-1:0] k_row;
    logic [1:0]                half;

    always_comb begin
        sel_clip = (kernel_reg > 2'(gws_pkg::KSEL_7X7)) ? 2'(gws_pkg::KSEL_7X7) : kernel_reg;
        eff_sel  = gws_pkg::gws_ksel_t'((sel_clip > SEL_MAX) ? SEL_MAX : sel_clip);
        half     = 2'(eff_sel) + 2'd1;
        k_col    = EW'({2'(eff_sel), 1'b1}) + EW'(2);
        k_row    = gws_pkg::CFG_W'({2'(eff_sel), 1'b1}) + gws_pkg::CFG_W'(2);

        if (width_reg == '0) begin
            w_eff = EW'(1);
        end else if (EW'(width_reg) > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(width_reg);
        end

        if (height_reg == '0) begin
            h_eff = gws_pkg::CFG_W'(1);
        end else if (height_reg > gws_pkg::MAX_HEIGHT) begin
            h_eff = gws_pkg::MAX_HEIGHT;
        end else begin
            h_eff = height_reg;
        end
    end

    // ---------------- position counters ----------------
    logic [COL_W-1:0]          col_cnt_reg;
    logic [COL_W-1:0]          col_cnt_next;
    logic [CW-1:0]             row_cnt_reg;
    logic [CW-1:0]             row_cnt_next;
    logic [COL_W-1:0]          c_cur;
    logic [CW-1:0]             r_cur;
    logic [EW-1:0]             c_ext;
    logic [EW-1:0]             c_inc;
    logic [EW-1:0]             c_minus;
    logic [gws_pkg::CFG_W-1:0] r_ext;
    logic [gws_pkg::CFG_W-1:0] r_inc;
    logic                      emit_cur;
    logic                      accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        // frame_start forces column 0 of row 0 for this beat
        c_cur   = s_data.frame_start ? '0 : col_cnt_reg;
        r_cur   = s_data.frame_start ? '0 : row_cnt_reg;
        c_ext   = EW'(c_cur);
        r_ext   = gws_pkg::CFG_W'(r_cur);
        c_inc   = c_ext + EW'(1);
        r_inc   = r_ext + gws_pkg::CFG_W'(1);
        c_minus = c_ext - EW'(half);

        // a full kernel fits above and to the left of this pixel
        emit_cur = (c_ext < w_eff) && (r_ext < h_eff) && (c_inc >= k_col) && (r_inc >= k_row);

        if (c_inc >= w_eff) begin
            col_cnt_next = '0;
            row_cnt_next = (r_inc >= h_eff) ? '0 : r_inc[CW-1:0];
        end else begin
            col_cnt_next = c_inc[COL_W-1:0];
            row_cnt_next = r_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ---------------- line store stage ----------------
    // each column address keeps the last ROWS pixels of that column, newest first
    logic                               st1_valid_reg;
    gws_pkg::gws_pixel_t                st1_px_reg;
    logic [COL_W-1:0]                   st1_addr_reg;
    logic [LINE_W-1:0]                  line_rd_bits;
    gws_pkg::gws_pixel_t [ROWS-1:0]     line_rd;
    gws_pkg::gws_pixel_t [MAX_KERNEL-1:0] new_col;
    logic [LINE_W-1:0]                  line_wr_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        st1_px_reg.red   <= s_data.pixel_red;
        st1_px_reg.green <= s_data.pixel_green;
        st1_px_reg.blue  <= s_data.pixel_blue;
        st1_addr_reg     <= c_cur;
    end

    gws_line_mem #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LINE_W)
    ) u_line_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (c_cur),
        .rd_data (line_rd_bits),
        .wr_en   (st1_valid_reg),
        .wr_addr (st1_addr_reg),
        .wr_data (line_wr_bits)
    );

    assign line_rd = line_rd_bits;

    // new window column: current pixel on top, stored rows below
    always_comb begin
        new_col[0] = st1_px_reg;
        for (int i = 1; i < MAX_KERNEL; i++) begin
            new_col[i] = line_rd[i-1];
        end
    end

    assign line_wr_bits = new_col[ROWS-1:0];

    // ---------------- window: row of column cells ----------------
    // cell MAX_KERNEL-1 takes the new column, every other cell takes its right neighbor
    gws_pkg::gws_pixel_t [MAX_KERNEL-1:0] cell_col  [MAX_KERNEL];
    gws_pkg::gws_pixel_t [MAX_KERNEL-1:0] cell_feed [MAX_KERNEL];
    gws_pkg::gws_sums_t                   cell_sum  [MAX_KERNEL];

    for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
        if (j == MAX_KERNEL - 1) begin : g_head
            assign cell_feed[j] = new_col;
        end else begin : g_body
            assign cell_feed[j] = cell_col[j+1];
        end

        gws_col_cell #(
            .MAX_KERNEL (MAX_KERNEL),
            .COL_IDX    (j)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (st1_valid_reg),
            .ksel     (eff_sel),
            .col_in   (cell_feed[j]),
            .col_out  (cell_col[j]),
            .col_sum  (cell_sum[j])
        );
    end

    // ---------------- window total ----------------
    gws_pkg::gws_sums_t total_reg;
    gws_pkg::gws_sums_t total_next;

    always_comb begin
        total_next = '0;
        for (int j = 0; j < MAX_KERNEL; j++) begin
            total_next.red   = total_next.red + cell_sum[j].red;
            total_next.green = total_next.green + cell_sum[j].green;
            total_next.blue  = total_next.blue + cell_sum[j].blue;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
    end

    // ---------------- divide by kernel sum, one lane per channel ----------------
    logic [gws_pkg::PIX_W-1:0] q_red;
    logic [gws_pkg::PIX_W-1:0] q_green;
    logic [gws_pkg::PIX_W-1:0] q_blue;

    gws_div u_div_red (
        .aclk   (aclk),
        .ksel   (eff_sel),
        .sum_in (total_reg.red),
        .quot   (q_red)
    );

    gws_div u_div_green (
        .aclk   (aclk),
        .ksel   (eff_sel),
        .sum_in (total_reg.green),
        .quot   (q_green)
    );

    gws_div u_div_blue (
        .aclk   (aclk),
        .ksel   (eff_sel),
        .sum_in (total_reg.blue),
        .quot   (q_blue)
    );

    // ---------------- emit flag and centre follow the datapath ----------------
    meta_t meta_reg [gws_pkg::PIPE_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < gws_pkg::PIPE_LAT; i++) begin
                meta_reg[i].emit <= 1'b0;
            end
        end else begin
            meta_reg[0].emit <= accept && emit_cur;
            for (int i = 1; i < gws_pkg::PIPE_LAT; i++) begin
                meta_reg[i].emit <= meta_reg[i-1].emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        meta_reg[0].col <= c_minus[CW-1:0];
        meta_reg[0].row <= r_cur - CW'(half);
        for (int i = 1; i < gws_pkg::PIPE_LAT; i++) begin
            meta_reg[i].col <= meta_reg[i-1].col;
            meta_reg[i].row <= meta_reg[i-1].row;
        end
    end

    // ---------------- result buffer ----------------
    // owed counts results promised at accept; it gates s_ready so the buffer never overflows
    gws_pkg::gws_out_t fifo_mem_reg [gws_pkg::OUT_DEPTH];
    gws_pkg::gws_out_t fifo_wr_data;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    fifo_cnt_reg;
    logic [PTR_W:0]    fifo_cnt_next;
    logic [PTR_W:0]    owed_reg;
    logic [PTR_W:0]    owed_next;
    logic              push;
    logic              pop;

    assign push = meta_reg[gws_pkg::PIPE_LAT-1].emit;
    assign pop  = m_valid && m_ready;

    always_comb begin
        fifo_wr_data.smooth_red   = q_red;
        fifo_wr_data.smooth_green = q_green;
        fifo_wr_data.smooth_blue  = q_blue;
        fifo_wr_data.centre_col   = meta_reg[gws_pkg::PIPE_LAT-1].col;
        fifo_wr_data.centre_row   = meta_reg[gws_pkg::PIPE_LAT-1].row;

        fifo_cnt_next = fifo_cnt_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
        owed_next     = owed_reg + (PTR_W + 1)'(accept && emit_cur) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= fifo_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            owed_reg     <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
            owed_reg     <= owed_next;
        end
    end

    assign s_ready = owed_reg < OUT_FULL;
    assign m_valid = fifo_cnt_reg != '0;
    assign m_data  = fifo_mem_reg[rd_ptr_reg];

    `GWS_ASSERT_NEVER(a_buf_le_owed, aclk, aresetn, fifo_cnt_reg > owed_reg, "result buffer holds more beats than owed")
    `GWS_ASSERT_NEVER(a_buf_overflow, aclk, aresetn, push && !pop && (fifo_cnt_reg == OUT_FULL), "result buffer overflow")
    `GWS_ASSERT_NEXT(a_owed_after_take, aclk, aresetn, accept && emit_cur, owed_reg != '0, "interior pixel taken but no result owed")
    `GWS_ASSERT_IMPLIES(a_out_owed, aclk, aresetn, m_valid, owed_reg != '0, "output beat shown while nothing owed")

endmodule

`default_nettype wire

FILE: sv/gws_line_mem.sv
`default_nettype none

`include "gaussian_window_smoother_macros.svh"

module gws_line_mem #(
    parameter int DEPTH = gws_pkg::MAX_WIDTH_DEF,
    parameter int WIDTH = (gws_pkg::MAX_KERNEL_DEF - 1) * 3 * gws_pkg::PIX_W
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_raw_reg;
    logic [WIDTH-1:0] byp_data_reg;
    logic             byp_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg   <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    // same-address write in the read cycle wins over the old word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : rd_raw_reg;

    `GWS_ASSERT_NEXT(a_fwd_write, aclk, aresetn, wr_en && (wr_addr == rd_addr), rd_data == $past(wr_data), "line store read missed a same-cycle write")

endmodule

`default_nettype wire

FILE: sv/gws_col_cell.sv
`default_nettype none

module gws_col_cell #(
    parameter int MAX_KERNEL = gws_pkg::MAX_KERNEL_DEF,
    parameter int COL_IDX    = 0
) (
    input  wire logic                                   aclk,
    input  wire logic                                   shift_en,
    input  wire gws_pkg::gws_ksel_t                     ksel,
    input  wire gws_pkg::gws_pixel_t [MAX_KERNEL-1:0]   col_in,
    output gws_pkg::gws_pixel_t      [MAX_KERNEL-1:0]   col_out,
    output gws_pkg::gws_sums_t                          col_sum
);

    gws_pkg::gws_pixel_t [MAX_KERNEL-1:0] col_reg;
    gws_pkg::gws_sums_t                   col_sum_reg;
    gws_pkg::gws_sums_t                   col_sum_next;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
        col_sum_reg <= col_sum_next;
    end

    // weighted column sum; row 0 is the newest line
    always_comb begin
        int                          k;
        int                          a;
        int                          b;
        logic [7:0]                  wt;
        logic [gws_pkg::SUM_W-1:0]   acc_r;
        logic [gws_pkg::SUM_W-1:0]   acc_g;
        logic [gws_pkg::SUM_W-1:0]   acc_b;
        k     = 3 + 2 * int'(ksel);
        b     = COL_IDX - (MAX_KERNEL - k);
        acc_r = '0;
        acc_g = '0;
        acc_b = '0;
        for (int wy = 0; wy < MAX_KERNEL; wy++) begin
            a = k - 1 - wy;
            if (a >= 0 && b >= 0 && b < k) begin
                wt = gws_pkg::gws_weight(ksel, a, b);
            end else begin
                wt = '0;
            end
            acc_r = acc_r + gws_pkg::SUM_W'(col_reg[wy].red) * gws_pkg::SUM_W'(wt);
            acc_g = acc_g + gws_pkg::SUM_W'(col_reg[wy].green) * gws_pkg::SUM_W'(wt);
            acc_b = acc_b + gws_pkg::SUM_W'(col_reg[wy].blue) * gws_pkg::SUM_W'(wt);
        end
        col_sum_next.red   = acc_r;
        col_sum_next.green = acc_g;
        col_sum_next.blue  = acc_b;
    end

    assign col_out = col_reg;
    assign col_sum = col_sum_reg;

endmodule

`default_nettype wire

FILE: sv/gws_div.sv
`default_nettype none

module gws_div (
    input  wire logic                      aclk,
    input  wire gws_pkg::gws_ksel_t        ksel,
    input  wire logic [gws_pkg::SUM_W-1:0] sum_in,
    output logic      [gws_pkg::PIX_W-1:0] quot
);

    localparam int PROD_W = gws_pkg::SUM_W + gws_pkg::RECIP_W;

    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         prod_next;
    logic [gws_pkg::SUM_W-1:0] s_a_reg;
    logic [gws_pkg::SUM_W-1:0] s_b_reg;
    logic [gws_pkg::PIX_W-1:0] q0_reg;
    logic [gws_pkg::PIX_W-1:0] q0_next;
    logic [gws_pkg::SUM_W-1:0] qd_reg;
    logic [gws_pkg::SUM_W-1:0] qd_next;
    logic [gws_pkg::SUM_W-1:0] rem;
    logic [gws_pkg::SUM_W-1:0] ksum;
    logic [gws_pkg::PIX_W-1:0] quot_reg;
    logic [gws_pkg::PIX_W-1:0] quot_next;

    // estimate by reciprocal, then one correction step
    always_comb begin
        ksum      = gws_pkg::SUM_W'(gws_pkg::gws_ksum(ksel));
        prod_next = PROD_W'(sum_in) * PROD_W'(gws_pkg::gws_recip(ksel));
        q0_next   = prod_reg[gws_pkg::DIV_SHIFT + gws_pkg::PIX_W - 1:gws_pkg::DIV_SHIFT];
        qd_next   = gws_pkg::SUM_W'(q0_next) * ksum;
        rem       = s_b_reg - qd_reg;
        quot_next = (rem >= ksum) ? q0_reg + gws_pkg::PIX_W'(1) : q0_reg;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        s_a_reg  <= sum_in;
        q0_reg   <= q0_next;
        qd_reg   <= qd_next;
        s_b_reg  <= s_a_reg;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire
